[src/alist_pkg.sv]
// shared types and constants for the array list unit
package alist_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic                  re;
    logic [IDX_W-1:0]      raddr;
  } mem_req_t;

endpackage

[src/alist_ram.sv]
// simple dual-port ram, one write and one registered read per cycle
module alist_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/alist_ctrl.sv]
// sequencer for insert, delete and search over the element ram
module alist_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        op,
  input  logic [6:0]                        position,
  input  logic signed [31:0]                item_value,
  output alist_pkg::mem_req_t               mem_req,
  input  logic [alist_pkg::VALUE_BITS-1:0]  mem_rdata,
  output logic                              result_valid,
  output logic [1:0]                        status,
  output logic                              found,
  output logic [5:0]                        match_position,
  output logic [6:0]                        entry_count,
  output logic                              last
);
  import alist_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SHIFT_UP = 6'b000010,
    S_SHIFT_DN = 6'b000100,
    S_PLACE    = 6'b001000,
    S_SEARCH   = 6'b010000,
    S_FLUSH    = 6'b100000
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      len;
  logic [IDX_W-1:0]      lim;
  logic [VALUE_BITS-1:0] val;
  logic [IDX_W-1:0]      rd_ptr;
  logic                  rd_more;
  logic [IDX_W-1:0]      wr_ptr;
  logic                  wr_live;
  logic [IDX_W-1:0]      pend_pos;
  logic                  pend_live;
  logic                  accept;
  logic                  hit;

  assign busy        = (state != S_IDLE);
  assign accept      = start && (state == S_IDLE);
  assign entry_count = len;
  assign hit         = wr_live && (mem_rdata == val);

  // ram request: direct append, shift traffic, search reads, final placement
  always_comb begin
    mem_req = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && (op == OP_INSERT) && (position == len) &&
            (len != CNT_W'(CAPACITY))) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = position[IDX_W-1:0];
          mem_req.wdata = item_value[VALUE_BITS-1:0];
        end
      end
      S_SHIFT_UP, S_SHIFT_DN: begin
        mem_req.re    = rd_more;
        mem_req.raddr = rd_ptr;
        mem_req.we    = wr_live;
        mem_req.waddr = wr_ptr;
        mem_req.wdata = mem_rdata;
      end
      S_SEARCH: begin
        mem_req.re    = rd_more;
        mem_req.raddr = rd_ptr;
      end
      S_PLACE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = lim;
        mem_req.wdata = val;
      end
      S_FLUSH: begin
        mem_req = '0;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      len          <= '0;
      rd_more      <= 1'b0;
      wr_live      <= 1'b0;
      pend_live    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid   <= 1'b0;
      found          <= 1'b0;
      match_position <= '0;
      last           <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (op)
              OP_INSERT: begin
                if (position > len) begin
                  result_valid <= 1'b1;
                  status       <= ST_RANGE;
                end else if (len == CNT_W'(CAPACITY)) begin
                  result_valid <= 1'b1;
                  status       <= ST_FULL;
                end else if (position == len) begin
                  len          <= len + CNT_W'(1);
                  result_valid <= 1'b1;
                  status       <= ST_OK;
                end else begin
                  lim     <= position[IDX_W-1:0];
                  val     <= item_value[VALUE_BITS-1:0];
                  rd_ptr  <= len[IDX_W-1:0] - IDX_W'(1);
                  rd_more <= 1'b1;
                  wr_live <= 1'b0;
                  state   <= S_SHIFT_UP;
                end
              end
              OP_DELETE: begin
                if (position >= len) begin
                  result_valid <= 1'b1;
                  status       <= ST_RANGE;
                end else if (position == len - CNT_W'(1)) begin
                  len          <= len - CNT_W'(1);
                  result_valid <= 1'b1;
                  status       <= ST_OK;
                end else begin
                  lim     <= len[IDX_W-1:0] - IDX_W'(1);
                  rd_ptr  <= position[IDX_W-1:0] + IDX_W'(1);
                  rd_more <= 1'b1;
                  wr_live <= 1'b0;
                  state   <= S_SHIFT_DN;
                end
              end
              OP_SEARCH: begin
                if (len == '0) begin
                  result_valid <= 1'b1;
                  status       <= ST_OK;
                end else begin
                  lim       <= len[IDX_W-1:0] - IDX_W'(1);
                  val       <= item_value[VALUE_BITS-1:0];
                  rd_ptr    <= '0;
                  rd_more   <= 1'b1;
                  wr_live   <= 1'b0;
                  pend_live <= 1'b0;
                  state     <= S_SEARCH;
                end
              end
              default: begin
                result_valid <= 1'b1;
                status       <= ST_RANGE;
              end
            endcase
          end
        end
        S_SHIFT_UP: begin
          if (rd_more) begin
            wr_ptr  <= rd_ptr + IDX_W'(1);
            wr_live <= 1'b1;
            if (rd_ptr == lim) begin
              rd_more <= 1'b0;
            end else begin
              rd_ptr <= rd_ptr - IDX_W'(1);
            end
          end else begin
            // last shifted entry lands this cycle
            wr_live <= 1'b0;
            state   <= S_PLACE;
          end
        end
        S_PLACE: begin
          len          <= len + CNT_W'(1);
          result_valid <= 1'b1;
          status       <= ST_OK;
          state        <= S_IDLE;
        end
        S_SHIFT_DN: begin
          if (rd_more) begin
            wr_ptr  <= rd_ptr - IDX_W'(1);
            wr_live <= 1'b1;
            if (rd_ptr == lim) begin
              rd_more <= 1'b0;
            end else begin
              rd_ptr <= rd_ptr + IDX_W'(1);
            end
          end else begin
            wr_live      <= 1'b0;
            len          <= len - CNT_W'(1);
            result_valid <= 1'b1;
            status       <= ST_OK;
            state        <= S_IDLE;
          end
        end
        S_SEARCH: begin
          if (rd_more) begin
            wr_ptr  <= rd_ptr;
            wr_live <= 1'b1;
            if (rd_ptr == lim) begin
              rd_more <= 1'b0;
            end else begin
              rd_ptr <= rd_ptr + IDX_W'(1);
            end
          end else begin
            wr_live <= 1'b0;
            state   <= S_FLUSH;
          end
          // a match is held back one step so the final one can carry last
          if (hit) begin
            if (pend_live) begin
              result_valid   <= 1'b1;
              status         <= ST_OK;
              found          <= 1'b1;
              match_position <= pend_pos;
              last           <= 1'b0;
            end
            pend_pos  <= wr_ptr;
            pend_live <= 1'b1;
          end
        end
        S_FLUSH: begin
          result_valid   <= 1'b1;
          status         <= ST_OK;
          found          <= pend_live;
          match_position <= pend_live ? pend_pos : '0;
          pend_live      <= 1'b0;
          state          <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/array_list_insert_delete_search_unit.sv]
// top level of the array list unit: sequencer plus element ram
//
// usage
// - a command transfers at a rising edge with start high and busy low:
//   op (insert, delete, search), position and item_value
// - results come out one per cycle as a one-cycle pulse on result_valid
//   with status, found, match_position, entry_count and last; the receiver
//   must take every pulse, there is no back-pressure
// - errors (list full, position out of range, unused op) give one result
//   the cycle after the command, list untouched
// - insert and delete at the tail also give their result the cycle after
// - insert at position p with n entries: one ram read and one ram write
//   per cycle while entries move up one place, then the item is placed at p
// - delete at position p: same shift walk downwards
// - search: one entry read per cycle; each match is held until the next
//   one is found so that the final one carries last
// - final result is on the ports in the first cycle with busy low
// - reset clears the entry count and control state, not the ram; the ram is
//   never read below the count before being written, so needs no clearing pass
module array_list_insert_delete_search_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [6:0]         position,
  input  logic signed [31:0] item_value,
  output logic               result_valid,
  output logic [1:0]         status,
  output logic               found,
  output logic [5:0]         match_position,
  output logic [6:0]         entry_count,
  output logic               last
);
  import alist_pkg::*;

  mem_req_t              mem_req;
  logic [VALUE_BITS-1:0] mem_rdata;

  // command sequencer, owns the entry count and the result register
  alist_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .position       (position),
    .item_value     (item_value),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata),
    .result_valid   (result_valid),
    .status         (status),
    .found          (found),
    .match_position (match_position),
    .entry_count    (entry_count),
    .last           (last)
  );

  // element store, read data registered and valid in the cycle after the address
  alist_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

[tb/tb_array_list_insert_delete_search_unit.sv]
// self-checking testbench for the array list insert/delete/search unit
module tb_array_list_insert_delete_search_unit;
  import alist_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int MAX_CYCLES    = 400000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_ITEMS  = 320;

  // the op encoding the block must reject
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    status_t          status;
    logic             found;
    logic [IDX_W-1:0] match_position;
    logic [CNT_W-1:0] entry_count;
    logic             last;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         op;
  logic [6:0]         position;
  logic signed [31:0] item_value;
  logic               result_valid;
  logic [1:0]         status;
  logic               found;
  logic [5:0]         match_position;
  logic [6:0]         entry_count;
  logic               last;

  array_list_insert_delete_search_unit dut (.*);

  always #CLK_HALF clk = ~clk;

  // shadow copy of the list, updated as each command transfers
  logic [VALUE_BITS-1:0] shadow_list [CAPACITY];
  int unsigned           shadow_len = 0;
  list_result_t          expected_q [$];

  int mismatches     = 0;
  int commands_sent  = 0;
  int results_seen   = 0;
  int search_hits    = 0;
  int max_hits       = 0;
  int full_count     = 0;
  int range_count    = 0;
  int peak_len       = 0;
  int burst_left     = 0;
  int cycle_count    = 0;

  // work out the results of one command and update the shadow list
  function automatic void predict_command(logic [1:0] c_op, logic [6:0] c_pos,
                                          logic [31:0] c_val);
    list_result_t r;
    int           hits;
    int           k;
    status_t      st;
    r.status         = ST_OK;
    r.found          = 1'b0;
    r.match_position = '0;
    r.last           = 1'b1;
    if (c_op == OP_SEARCH) begin
      hits = 0;
      k    = 0;
      for (int i = 0; i < shadow_len; i++)
        if (shadow_list[i] == c_val) hits++;
      r.entry_count = CNT_W'(shadow_len);
      // one result per matching index in rising order, last on the final one
      for (int i = 0; i < shadow_len; i++) begin
        if (shadow_list[i] == c_val) begin
          k++;
          r.found          = 1'b1;
          r.match_position = IDX_W'(i);
          r.last           = (k == hits);
          expected_q.push_back(r);
        end
      end
      if (hits == 0) expected_q.push_back(r);
      search_hits += hits;
      if (hits > max_hits) max_hits = hits;
      return;
    end
    case (c_op)
      OP_INSERT: begin
        // position check wins over the full check
        if (c_pos > shadow_len) st = ST_RANGE;
        else if (shadow_len >= CAPACITY) st = ST_FULL;
        else begin
          for (int i = shadow_len; i > c_pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[c_pos] = c_val;
          shadow_len++;
          st = ST_OK;
        end
      end
      OP_DELETE: begin
        if (c_pos >= shadow_len) st = ST_RANGE;
        else begin
          for (int i = c_pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
          st = ST_OK;
        end
      end
      default: st = ST_RANGE;
    endcase
    if (st == ST_FULL) full_count++;
    if (st == ST_RANGE) range_count++;
    if (shadow_len > peak_len) peak_len = shadow_len;
    r.status      = st;
    r.entry_count = CNT_W'(shadow_len);
    expected_q.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [6:0] want, logic [6:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // every strobe is compared with the oldest outstanding expectation
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst && result_valid) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result with nothing outstanding: status %0d found %0d pos %0d",
               status, found, match_position);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("status", 7'(want.status), 7'(status));
        check_field("found", 7'(want.found), 7'(found));
        check_field("match_position", 7'(want.match_position), 7'(match_position));
        check_field("entry_count", want.entry_count, entry_count);
        check_field("last", 7'(want.last), 7'(last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // sender works in bursts; a gap drops start for a random number of cycles
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(0, 8);
    end
  endtask

  // hold the command until it transfers, then predict its results
  task automatic send_command(logic [1:0] c_op, logic [6:0] c_pos, logic [31:0] c_val);
    start      <= 1'b1;
    op         <= c_op;
    position   <= c_pos;
    item_value <= c_val;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_command(c_op, c_pos, c_val);
    commands_sent++;
    pace_sender();
  endtask

  // sender pauses until every outstanding result has been seen
  task automatic wait_results_drained();
    start <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 3);
      3, 4: return (shadow_len > 0) ? shadow_list[$urandom_range(0, shadow_len - 1)]
                                    : $urandom();
      default: return $urandom();
    endcase
  endfunction

  // extremes, every op and the range error paths on a short list
  task automatic test_directed_edges();
    send_command(OP_SEARCH, 7'd0, 32'd0);             // search on empty list
    send_command(OP_DELETE, 7'd0, 32'd0);             // delete from empty list
    send_command(OP_INSERT, 7'd1, 32'd5);             // insert beyond count
    send_command(OP_INSERT, 7'd127, 32'hffff_ffff);
    send_command(OP_INSERT, 7'd0, 32'h7fff_ffff);
    send_command(OP_INSERT, 7'd1, 32'h8000_0000);     // tail
    send_command(OP_INSERT, 7'd0, 32'd0);             // head
    send_command(OP_INSERT, 7'd1, 32'hffff_ffff);     // middle
    send_command(OP_INSERT, 7'd4, 32'h7fff_ffff);     // duplicate at tail
    send_command(OP_SEARCH, 7'd0, 32'h7fff_ffff);     // two matches
    send_command(OP_SEARCH, 7'd127, 32'h8000_0000);   // position ignored
    send_command(OP_SEARCH, 7'd64, 32'hffff_ffff);
    send_command(OP_SEARCH, 7'd0, 32'd12345);         // no match
    send_command(OP_UNUSED, 7'd127, 32'hffff_ffff);
    send_command(OP_UNUSED, 7'd0, 32'd0);
    send_command(OP_DELETE, 7'd5, 32'd0);             // position equal to count
    send_command(OP_DELETE, 7'd127, 32'd0);
    send_command(OP_INSERT, 7'd6, 32'd9);             // one past count
    send_command(OP_DELETE, 7'd2, 32'd0);             // middle
    send_command(OP_DELETE, 7'd0, 32'd0);             // head
    send_command(OP_DELETE, 7'd2, 32'd0);             // tail
    send_command(OP_SEARCH, 7'd0, 32'hffff_ffff);
    send_command(OP_SEARCH, 7'd0, 32'd0);
  endtask

  // empty the list, fill it with one value, then push past full
  task automatic test_fill_and_overflow();
    while (shadow_len > 0)
      send_command(OP_DELETE, 7'($urandom_range(0, shadow_len - 1)), 32'd0);
    while (shadow_len < CAPACITY)
      send_command(OP_INSERT, 7'($urandom_range(0, shadow_len)), 32'd7);
    send_command(OP_SEARCH, 7'd0, 32'd7);             // every entry matches
    send_command(OP_INSERT, 7'd0, 32'd1);             // full
    send_command(OP_INSERT, 7'd64, 32'd1);            // full at the tail
    send_command(OP_INSERT, 7'd65, 32'd1);            // range wins over full
    send_command(OP_INSERT, 7'd127, 32'd1);
    send_command(OP_DELETE, 7'd64, 32'd0);
    send_command(OP_DELETE, 7'd63, 32'd0);
    send_command(OP_INSERT, 7'd63, 32'h8000_0000);
    send_command(OP_SEARCH, 7'd0, 32'h8000_0000);
    repeat (30) begin
      if ($urandom_range(0, 1) == 0)
        send_command(OP_DELETE, 7'($urandom_range(0, shadow_len - 1)), 32'd0);
      else
        send_command(OP_INSERT, 7'($urandom_range(0, shadow_len)), pick_value());
    end
    send_command(OP_SEARCH, 7'd0, 32'd7);
  endtask

  // mostly well-formed commands, with the list swept between empty and full
  task automatic test_random_mix(int n_items);
    logic [1:0] c_op;
    logic [6:0] c_pos;
    int         roll;
    bit         growing;
    growing = 1'b1;
    repeat (n_items) begin
      if (shadow_len == CAPACITY) growing = 1'b0;
      else if (shadow_len == 0) growing = 1'b1;
      else if ($urandom_range(0, 59) == 0) growing = !growing;
      roll = $urandom_range(0, 99);
      if (roll < 4) c_op = OP_UNUSED;
      else if (roll < 24) c_op = OP_SEARCH;
      else if (roll < 80) c_op = growing ? OP_INSERT : OP_DELETE;
      else c_op = growing ? OP_DELETE : OP_INSERT;
      if ($urandom_range(0, 9) == 0) c_pos = 7'($urandom_range(0, 127));
      else if (c_op == OP_DELETE && shadow_len > 0)
        c_pos = 7'($urandom_range(0, shadow_len - 1));
      else c_pos = 7'($urandom_range(0, shadow_len));
      send_command(c_op, c_pos, pick_value());
      if ($urandom_range(0, 149) == 0) wait_results_drained();
    end
  endtask

  // delete down to empty, then the empty-list cases once more
  task automatic test_empty_out();
    while (shadow_len > 0) begin
      case ($urandom_range(0, 2))
        0: send_command(OP_DELETE, 7'd0, 32'd0);
        1: send_command(OP_DELETE, 7'(shadow_len - 1), 32'd0);
        default: send_command(OP_DELETE, 7'($urandom_range(0, shadow_len - 1)), 32'd0);
      endcase
    end
    send_command(OP_SEARCH, 7'd0, 32'd7);
    send_command(OP_DELETE, 7'd0, 32'd0);
  endtask

  initial begin
    rst        <= 1'b1;
    start      <= 1'b0;
    op         <= OP_INSERT;
    position   <= '0;
    item_value <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    wait_results_drained();
    test_fill_and_overflow();
    wait_results_drained();
    test_random_mix(RANDOM_ITEMS);
    wait_results_drained();
    test_empty_out();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d commands, %0d results checked, %0d search hits (up to %0d in one search)",
             commands_sent, results_seen, search_hits, max_hits);
    $display("list peaked at %0d entries; %0d full and %0d out-of-range statuses",
             peak_len, full_count, range_count);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
src/alist_pkg.sv
src/alist_ram.sv
src/alist_ctrl.sv
src/array_list_insert_delete_search_unit.sv
tb/tb_array_list_insert_delete_search_unit.sv
